// ----- src/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that is also checked through reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ----- src/dea_pkg.sv -----
// Types and constants for the dual encoder delta accumulator.
package dea_pkg;

    localparam int CNT_W  = 16;
    localparam int SUM_W  = 32;
    localparam int WORD_W = 32;

    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [CNT_W-1:0]  step_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [WORD_W-1:0]        word_t;

    // Operation codes carried on s_tuser
    typedef enum logic [2:0] {
        OP_BOTH  = 3'd0,
        OP_LEFT  = 3'd1,
        OP_RIGHT = 3'd2,
        OP_READ  = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    // Configuration register indexes
    localparam logic CFG_LEFT_REV  = 1'b0;
    localparam logic CFG_RIGHT_REV = 1'b1;

    // Delta and sum values at the edges of the signed range
    localparam step_t STEP_MIN = step_t'({1'b1, {(CNT_W-1){1'b0}}});
    localparam step_t STEP_MAX = step_t'({1'b0, {(CNT_W-1){1'b1}}});
    localparam sum_t  SUM_MIN  = sum_t'({1'b1, {(SUM_W-1){1'b0}}});
    localparam sum_t  SUM_MAX  = sum_t'({1'b0, {(SUM_W-1){1'b1}}});

    // Result word fields
    typedef struct packed {
        word_t stamp_ms;
        word_t sample_number;
        sum_t  right_sum;
        sum_t  left_sum;
        step_t right_step;
        step_t left_step;
    } result_t;

endpackage

// ----- src/dea_channel.sv -----
// One encoder channel: wrapped delta, optional reversal, saturating total.
module dea_channel (
    input  dea_pkg::cnt_t  cur_count,
    input  dea_pkg::cnt_t  prev_count,
    input  logic           reversed,
    input  dea_pkg::sum_t  accum,
    output dea_pkg::step_t step,
    output dea_pkg::sum_t  sum_next
);
    import dea_pkg::*;

    step_t                raw_delta;
    logic signed [SUM_W:0] sum_wide;

    // 16-bit wrapped difference read as two's complement
    assign raw_delta = step_t'(cur_count - prev_count);

    // Reversal; the most negative delta clamps to the most positive
    always_comb begin
        if (!reversed) begin
            step = raw_delta;
        end else if (raw_delta == STEP_MIN) begin
            step = STEP_MAX;
        end else begin
            step = -raw_delta;
        end
    end

    // Saturating add into the running total
    assign sum_wide = {accum[SUM_W-1], accum}
                    + {{(SUM_W-CNT_W+1){step[CNT_W-1]}}, step};

    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

endmodule

// ----- src/dual_encoder_delta_accumulator.sv -----
// Flow: a word is loaded into the input register, and its result word is
// loaded into the result register when that register is free or being drained.
// Throughput: one word per cycle while m_tready does not stall the result stream;
// the state registers are written with the result register, so back-to-back ops see each other's state without stalls.
// Reset (aresetn low, synchronous): both channels cleared, left reversed,
// right not reversed, both stages empty.
module dual_encoder_delta_accumulator (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic         cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // left_count[15:0], right_count[31:16], now_ms[63:32]
    input  logic [2:0]   s_tuser,   // op[2:0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // left_step, right_step, left_sum, right_sum,
                                    // sample_number, stamp_ms (lowest first)
    output logic [0:0]   m_tuser    // ok[0]
);
    import dea_pkg::*;

    // configuration
    logic left_rev_reg, right_rev_reg;

    // input register
    logic  in_valid_reg;
    op_t   op_reg;
    cnt_t  left_count_reg, right_count_reg;
    word_t now_ms_reg;

    // block state
    cnt_t  left_prev_reg, right_prev_reg;
    cnt_t  left_prev_next, right_prev_next;
    sum_t  left_accum_reg, right_accum_reg;
    sum_t  left_accum_next, right_accum_next;
    step_t latest_left_reg, latest_right_reg;
    step_t latest_left_next, latest_right_next;
    word_t seq_count_reg, seq_count_next;
    word_t latest_stamp_reg, latest_stamp_next;
    logic  have_sample_reg, have_sample_next;

    // result register
    logic    out_valid_reg;
    logic    ok_reg, ok_next;
    result_t result_reg, result_next;

    // channel units
    step_t left_chan_step, right_chan_step;
    sum_t  left_sum_upd, right_sum_upd;

    logic advance, fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    dea_channel u_left (
        .cur_count  (left_count_reg),
        .prev_count (left_prev_reg),
        .reversed   (left_rev_reg),
        .accum      (left_accum_reg),
        .step       (left_chan_step),
        .sum_next   (left_sum_upd)
    );

    dea_channel u_right (
        .cur_count  (right_count_reg),
        .prev_count (right_prev_reg),
        .reversed   (right_rev_reg),
        .accum      (right_accum_reg),
        .step       (right_chan_step),
        .sum_next   (right_sum_upd)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_rev_reg  <= 1'b1;
            right_rev_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LEFT_REV:  left_rev_reg  <= cfg_data;
                CFG_RIGHT_REV: right_rev_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            op_reg          <= op_t'(s_tuser);
            left_count_reg  <= s_tdata[15:0];
            right_count_reg <= s_tdata[31:16];
            now_ms_reg      <= s_tdata[63:32];
        end
    end

    // op decode, state update and result word
    always_comb begin
        left_prev_next    = left_prev_reg;
        right_prev_next   = right_prev_reg;
        left_accum_next   = left_accum_reg;
        right_accum_next  = right_accum_reg;
        latest_left_next  = latest_left_reg;
        latest_right_next = latest_right_reg;
        seq_count_next    = seq_count_reg;
        latest_stamp_next = latest_stamp_reg;
        have_sample_next  = have_sample_reg;
        ok_next           = 1'b0;
        result_next.left_step  = '0;
        result_next.right_step = '0;

        case (op_reg)
            OP_BOTH: begin
                left_prev_next    = left_count_reg;
                right_prev_next   = right_count_reg;
                left_accum_next   = left_sum_upd;
                right_accum_next  = right_sum_upd;
                latest_left_next  = left_chan_step;
                latest_right_next = right_chan_step;
                seq_count_next    = seq_count_reg + 1'b1;
                latest_stamp_next = now_ms_reg;
                have_sample_next  = 1'b1;
                ok_next           = 1'b1;
                result_next.left_step  = left_chan_step;
                result_next.right_step = right_chan_step;
            end
            OP_LEFT: begin
                left_prev_next  = left_count_reg;
                left_accum_next = left_sum_upd;
                ok_next         = 1'b1;
                result_next.left_step = left_chan_step;
            end
            OP_RIGHT: begin
                right_prev_next  = right_count_reg;
                right_accum_next = right_sum_upd;
                ok_next          = 1'b1;
                result_next.right_step = right_chan_step;
            end
            OP_READ: begin
                if (have_sample_reg) begin
                    ok_next = 1'b1;
                    result_next.left_step  = latest_left_reg;
                    result_next.right_step = latest_right_reg;
                end
            end
            OP_CLEAR: begin
                left_prev_next    = '0;
                right_prev_next   = '0;
                left_accum_next   = '0;
                right_accum_next  = '0;
                latest_left_next  = '0;
                latest_right_next = '0;
                seq_count_next    = '0;
                latest_stamp_next = '0;
                have_sample_next  = 1'b0;
                ok_next           = 1'b1;
            end
            default: ;
        endcase

        result_next.left_sum      = left_accum_next;
        result_next.right_sum     = right_accum_next;
        result_next.sample_number = seq_count_next;
        result_next.stamp_ms      = latest_stamp_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_prev_reg    <= '0;
            right_prev_reg   <= '0;
            left_accum_reg   <= '0;
            right_accum_reg  <= '0;
            latest_left_reg  <= '0;
            latest_right_reg <= '0;
            seq_count_reg    <= '0;
            latest_stamp_reg <= '0;
            have_sample_reg  <= 1'b0;
        end else if (fire) begin
            left_prev_reg    <= left_prev_next;
            right_prev_reg   <= right_prev_next;
            left_accum_reg   <= left_accum_next;
            right_accum_reg  <= right_accum_next;
            latest_left_reg  <= latest_left_next;
            latest_right_reg <= latest_right_next;
            seq_count_reg    <= seq_count_next;
            latest_stamp_reg <= latest_stamp_next;
            have_sample_reg  <= have_sample_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            ok_reg     <= ok_next;
            result_reg <= result_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = result_reg;
    assign m_tuser[0] = ok_reg;

endmodule

// ----- src/dea_checker.sv -----
// Port-level checker for the dual encoder delta accumulator, with its bind.
`include "assert_macros.svh"

module dea_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // a stalled result word holds
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // a failed op reports zero steps
    `ASSERT_CLK(a_fail_no_step, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'd0)

    // reset empties both stages
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid && s_tready)

    // successive results: sample count holds, steps by one, or clears
    `ASSERT_CLK(a_seq_step, aclk, aresetn, m_tvalid && m_tready ##1 m_tvalid |-> m_tdata[127:96] == $past(m_tdata[127:96]) || m_tdata[127:96] == $past(m_tdata[127:96]) + 32'd1 || m_tdata[127:96] == 32'd0)

endmodule

bind dual_encoder_delta_accumulator dea_checker u_dea_checker (.*);
